@@ design/sfc_pkg.sv @@
`default_nettype none
package sfc_pkg;

  // Byte range covered by the 16-bit frame sum
  localparam int SumFirst = 1;
  localparam int SumLast  = 30;

  // Checksum byte positions
  localparam int ChkLowPos  = 31;
  localparam int ChkHighPos = 32;

  // Field byte positions
  localparam int PosIdx0   = 12;
  localparam int PosIdx1   = 13;
  localparam int PosIdx2   = 14;
  localparam int PosId0    = 17;
  localparam int PosId1    = 18;
  localparam int PosId2    = 19;
  localparam int PosStatus = 20;
  localparam int PosB25    = 25;
  localparam int PosB26    = 26;

  // Door rule on the 24-bit card number
  localparam logic [23:0] DoorIdMin = 24'd100;
  localparam logic [23:0] DoorIdAlt = 24'd5;

  typedef struct packed {
    logic        last;     // next byte to arrive is the final byte of the frame
    logic        chk_ok;   // both checksum bytes matched
    logic [23:0] index;    // bytes 14:13:12
    logic [23:0] card;     // bytes 19:18:17
    logic [7:0]  status;   // byte 20
    logic [7:0]  b25;      // byte 25
    logic [7:0]  b26;      // byte 26
  } frame_info_t;

endpackage
`default_nettype wire

@@ design/sfc_rx_tracker.sv @@
`default_nettype none
module sfc_rx_tracker #(
  parameter int FRAME_LENGTH = 34
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_valid_i,
  input  wire logic [7:0]           byte_i,
  output sfc_pkg::frame_info_t      info_o
);

  localparam int PosW = $clog2(FRAME_LENGTH);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic            match_q, match_d;
  logic [7:0]      cap_q [9];
  logic            is_last;

  assign is_last = (pos_q == LastPos);

  always_comb begin
    pos_d   = is_last ? '0 : pos_q + PosW'(1);
    sum_d   = sum_q;
    match_d = match_q;
    if (pos_q == '0) begin
      sum_d   = '0;
      match_d = 1'b0;
    end
    if (pos_q >= PosW'(sfc_pkg::SumFirst) && pos_q <= PosW'(sfc_pkg::SumLast)) begin
      sum_d = sum_q + {8'h00, byte_i};
    end
    if (pos_q == PosW'(sfc_pkg::ChkLowPos)) begin
      match_d = (sum_q[7:0] == byte_i);
    end
    if (pos_q == PosW'(sfc_pkg::ChkHighPos)) begin
      match_d = match_q && (sum_q[15:8] == byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      match_q <= 1'b0;
    end else if (byte_valid_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      match_q <= match_d;
    end
  end

  // capture field bytes; no reset, every slot is written before the last byte
  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      case (pos_q)
        PosW'(sfc_pkg::PosIdx0):   cap_q[0] <= byte_i;
        PosW'(sfc_pkg::PosIdx1):   cap_q[1] <= byte_i;
        PosW'(sfc_pkg::PosIdx2):   cap_q[2] <= byte_i;
        PosW'(sfc_pkg::PosId0):    cap_q[3] <= byte_i;
        PosW'(sfc_pkg::PosId1):    cap_q[4] <= byte_i;
        PosW'(sfc_pkg::PosId2):    cap_q[5] <= byte_i;
        PosW'(sfc_pkg::PosStatus): cap_q[6] <= byte_i;
        PosW'(sfc_pkg::PosB25):    cap_q[7] <= byte_i;
        PosW'(sfc_pkg::PosB26):    cap_q[8] <= byte_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    info_o.last   = is_last;
    info_o.chk_ok = match_q;
    info_o.index  = {cap_q[2], cap_q[1], cap_q[0]};
    info_o.card   = {cap_q[5], cap_q[4], cap_q[3]};
    info_o.status = cap_q[6];
    info_o.b25    = cap_q[7];
    info_o.b26    = cap_q[8];
  end

endmodule
`default_nettype wire

@@ design/status_frame_checker_unit.sv @@
`default_nettype none
// Status frame checker: takes the controller's reply one byte per transaction and
// counts fixed frames of FRAME_LENGTH bytes from reset. A byte is taken every cycle;
// the only stall is on the final byte of a frame while the previous frame's result is
// still waiting on out_ready_i, since the single result register holds one result.
// The result appears on the output in the cycle after the final byte is accepted.
// frame_ok_o reports the checksum (bytes 31 low, 32 high against the sum of bytes 1
// to 30); the other fields show the values of the last good frame, zero until one
// has been seen.
module status_frame_checker_unit #(
  parameter int FRAME_LENGTH = 34
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             frame_ok_o,
  output logic [24:0]      next_index_o,
  output logic [7:0]       card_area_o,
  output logic [15:0]      card_id_o,
  output logic [7:0]       record_status_o,
  output logic             door_open_o,
  output logic [7:0]       record_flag_byte_o
);

  sfc_pkg::frame_info_t info;
  logic in_accept;
  logic last_accept;
  logic door_d;

  logic        out_valid_q;
  logic        frame_ok_q;
  logic [24:0] index_q;
  logic [7:0]  area_q;
  logic [15:0] card_id_q;
  logic [7:0]  status_q;
  logic        door_q;
  logic [7:0]  flag_q;

  // hold off the final byte while the previous result is still pending
  assign in_ready_o  = !info.last || !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign last_accept = in_accept && info.last;

  sfc_rx_tracker #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_accept),
    .byte_i      (rx_byte_i),
    .info_o      (info)
  );

  assign door_d = ((info.card > sfc_pkg::DoorIdMin) || (info.card == '0) ||
                   (info.card == sfc_pkg::DoorIdAlt)) && (info.b25 == 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      frame_ok_q  <= 1'b0;
      index_q     <= '0;
      area_q      <= '0;
      card_id_q   <= '0;
      status_q    <= '0;
      door_q      <= 1'b0;
      flag_q      <= '0;
    end else begin
      if (last_accept) begin
        out_valid_q <= 1'b1;
        frame_ok_q  <= info.chk_ok;
        // update stored fields on a good frame only
        if (info.chk_ok) begin
          index_q   <= {1'b0, info.index} + 25'd1;
          area_q    <= info.card[23:16];
          card_id_q <= info.card[15:0];
          status_q  <= info.status;
          door_q    <= door_d;
          flag_q    <= info.b26;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_ok_o         = frame_ok_q;
  assign next_index_o       = index_q;
  assign card_area_o        = area_q;
  assign card_id_o          = card_id_q;
  assign record_status_o    = status_q;
  assign door_open_o        = door_q;
  assign record_flag_byte_o = flag_q;

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_accept |=> out_valid_o)
    else $error("final byte accepted without a result");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !last_accept)
    else $error("pending result overwritten");

  a_fields_hold_mid_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !info.last) |=> ($stable(next_index_o) && $stable(card_id_o)))
    else $error("stored fields changed mid frame");

  a_bad_frame_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_accept && !info.chk_ok) |=> ($stable(next_index_o) && $stable(door_open_o)))
    else $error("bad frame changed stored fields");

endmodule
`default_nettype wire

@@ dv/status_frame_checker_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module status_frame_checker_unit_tb;

  localparam int FrameBytes  = 34;
  localparam int RandomBytes = 1540;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;

  typedef logic [7:0] frame_bytes_t [FrameBytes];

  typedef enum int {ChkClean, ChkBadLow, ChkBadHigh, ChkBadBoth} chk_fault_e;

  typedef struct packed {
    logic        frame_ok;
    logic [24:0] next_index;
    logic [7:0]  card_area;
    logic [15:0] card_id;
    logic [7:0]  record_status;
    logic        door_open;
    logic [7:0]  record_flag_byte;
  } status_result_t;

  // Tracks frame position, sum and field bytes, and the values of the last good frame.
  class frame_scoreboard;
    logic [5:0]     pos;
    logic [15:0]    sum;
    logic           chk_ok;
    logic [23:0]    index;
    logic [23:0]    card;
    logic [7:0]     status;
    logic [7:0]     b25;
    logic [7:0]     b26;
    status_result_t kept;
    status_result_t frame_results_q[$];

    function new();
      pos    = '0;
      sum    = '0;
      chk_ok = 1'b0;
      index  = '0;
      card   = '0;
      status = '0;
      b25    = '0;
      b26    = '0;
      kept   = '0;
    endfunction

    function void absorb_byte(logic [7:0] b);
      if (pos == 0) begin
        sum    = '0;
        chk_ok = 1'b0;
      end
      if (pos >= sfc_pkg::SumFirst && pos <= sfc_pkg::SumLast) sum = sum + 16'(b);
      case (pos)
        sfc_pkg::PosIdx0:   index[7:0]   = b;
        sfc_pkg::PosIdx1:   index[15:8]  = b;
        sfc_pkg::PosIdx2:   index[23:16] = b;
        sfc_pkg::PosId0:    card[7:0]    = b;
        sfc_pkg::PosId1:    card[15:8]   = b;
        sfc_pkg::PosId2:    card[23:16]  = b;
        sfc_pkg::PosStatus: status       = b;
        sfc_pkg::PosB25:    b25          = b;
        sfc_pkg::PosB26:    b26          = b;
        default: ;
      endcase
      if (pos == sfc_pkg::ChkLowPos) chk_ok = (sum[7:0] == b);
      if (pos == sfc_pkg::ChkHighPos) chk_ok = chk_ok && (sum[15:8] == b);
      if (pos == FrameBytes - 1) begin
        pos = '0;
        // a bad frame keeps the previous good values
        if (chk_ok) begin
          kept.next_index       = 25'(index) + 25'd1;
          kept.card_area        = card[23:16];
          kept.card_id          = card[15:0];
          kept.record_status    = status;
          kept.door_open        = (card > sfc_pkg::DoorIdMin || card == 24'd0 ||
                                   card == sfc_pkg::DoorIdAlt) && b25 == 8'd0;
          kept.record_flag_byte = b26;
        end
        kept.frame_ok = chk_ok;
        frame_results_q.push_back(kept);
      end else begin
        pos = pos + 6'd1;
      end
    endfunction

    function bit match_result(status_result_t got, output string diff);
      status_result_t want;
      diff = "";
      if (frame_results_q.size() == 0) begin
        diff = "result with no frame pending";
        return 1'b0;
      end
      want = frame_results_q.pop_front();
      if (got.frame_ok !== want.frame_ok)
        diff = {diff, $sformatf(" frame_ok %0b/%0b", got.frame_ok, want.frame_ok)};
      if (got.next_index !== want.next_index)
        diff = {diff, $sformatf(" next_index %h/%h", got.next_index, want.next_index)};
      if (got.card_area !== want.card_area)
        diff = {diff, $sformatf(" card_area %h/%h", got.card_area, want.card_area)};
      if (got.card_id !== want.card_id)
        diff = {diff, $sformatf(" card_id %h/%h", got.card_id, want.card_id)};
      if (got.record_status !== want.record_status)
        diff = {diff, $sformatf(" record_status %h/%h", got.record_status,
                                want.record_status)};
      if (got.door_open !== want.door_open)
        diff = {diff, $sformatf(" door_open %0b/%0b", got.door_open, want.door_open)};
      if (got.record_flag_byte !== want.record_flag_byte)
        diff = {diff, $sformatf(" record_flag_byte %h/%h", got.record_flag_byte,
                                want.record_flag_byte)};
      return diff == "";
    endfunction

    function int pending();
      return frame_results_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        frame_ok_o;
  logic [24:0] next_index_o;
  logic [7:0]  card_area_o;
  logic [15:0] card_id_o;
  logic [7:0]  record_status_o;
  logic        door_open_o;
  logic [7:0]  record_flag_byte_o;

  frame_scoreboard sb;
  int              mismatches;
  int              bytes_sent;
  bit              calm;
  bit              hold_req;

  status_frame_checker_unit #(.FRAME_LENGTH(FrameBytes)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_ok_o        (frame_ok_o),
    .next_index_o      (next_index_o),
    .card_area_o       (card_area_o),
    .card_id_o         (card_id_o),
    .record_status_o   (record_status_o),
    .door_open_o       (door_open_o),
    .record_flag_byte_o(record_flag_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t:%s", $time, what);
    mismatches++;
  endtask

  // Hold valid and the byte until the transaction is taken.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_bytes_t f);
    for (int i = 0; i < FrameBytes; i++) send_byte(f[i]);
  endtask

  function automatic frame_bytes_t make_frame(input logic [23:0] index,
                                               input logic [23:0] card,
                                               input logic [7:0]  status,
                                               input logic [7:0]  b25,
                                               input logic [7:0]  b26,
                                               input chk_fault_e  fault,
                                               input int          fill);
    frame_bytes_t f;
    logic [15:0]  sum;
    sum = '0;
    foreach (f[i]) f[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    {f[sfc_pkg::PosIdx2], f[sfc_pkg::PosIdx1], f[sfc_pkg::PosIdx0]} = index;
    {f[sfc_pkg::PosId2], f[sfc_pkg::PosId1], f[sfc_pkg::PosId0]}    = card;
    f[sfc_pkg::PosStatus] = status;
    f[sfc_pkg::PosB25]    = b25;
    f[sfc_pkg::PosB26]    = b26;
    for (int i = sfc_pkg::SumFirst; i <= sfc_pkg::SumLast; i++) sum = sum + 16'(f[i]);
    f[sfc_pkg::ChkLowPos]  = sum[7:0];
    f[sfc_pkg::ChkHighPos] = sum[15:8];
    if (fault == ChkBadLow || fault == ChkBadBoth)
      f[sfc_pkg::ChkLowPos] = f[sfc_pkg::ChkLowPos] ^ 8'($urandom_range(255, 1));
    if (fault == ChkBadHigh || fault == ChkBadBoth)
      f[sfc_pkg::ChkHighPos] = f[sfc_pkg::ChkHighPos] ^ 8'($urandom_range(255, 1));
    return f;
  endfunction

  function automatic logic [23:0] pick_card();
    case ($urandom_range(5))
      0:       return 24'd0;
      1:       return sfc_pkg::DoorIdAlt;
      2:       return 24'($urandom_range(110));
      3:       return sfc_pkg::DoorIdMin + 24'($urandom_range(1));
      default: return 24'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold on request.
  initial begin : receiver
    int             hold_left;
    status_result_t got;
    string          diff;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {frame_ok_o, next_index_o, card_area_o, card_id_o, record_status_o,
               door_open_o, record_flag_byte_o};
        if (!sb.match_result(got, diff)) report_mismatch(diff);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(99) >= 15;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** status_frame_checker_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int  start;
    int  run;
    bit  hold_done;
    bit  drain_done;
    int  kind;
    sb         = new();
    mismatches = 0;
    bytes_sent = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad frame before any good one, all-zero and all-ones frames, index carry
    // into bit 24, card ids around the door rule, each checksum fault.
    send_frame(make_frame(24'h123456, 24'd200, 8'h11, 8'h00, 8'h22, ChkBadLow, -1));
    send_frame(make_frame(24'h000000, 24'd0, 8'h00, 8'h00, 8'h00, ChkClean, 0));
    send_frame(make_frame(24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, ChkClean, 255));
    send_frame(make_frame(24'h000010, sfc_pkg::DoorIdMin, 8'h01, 8'h00, 8'h80, ChkClean,
                          -1));
    send_frame(make_frame(24'h000011, 24'd101, 8'h02, 8'h00, 8'h40, ChkClean, -1));
    send_frame(make_frame(24'h000012, sfc_pkg::DoorIdAlt, 8'h03, 8'h00, 8'h20, ChkClean,
                          -1));
    send_frame(make_frame(24'h000013, 24'd4, 8'h04, 8'h00, 8'h10, ChkClean, -1));
    send_frame(make_frame(24'h000014, 24'h010000, 8'h05, 8'h00, 8'h08, ChkClean, -1));
    send_frame(make_frame(24'h000015, 24'd0, 8'h06, 8'h01, 8'h04, ChkClean, -1));
    send_frame(make_frame(24'h555555, 24'd300, 8'h07, 8'h00, 8'h02, ChkBadHigh, -1));
    send_frame(make_frame(24'hAAAAAA, 24'd301, 8'h08, 8'h00, 8'h01, ChkBadBoth, -1));
    send_frame(make_frame(24'($urandom), pick_card(), 8'($urandom), 8'h00, 8'($urandom),
                          ChkClean, -1));

    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      run  = bytes_sent - start;
      calm = run >= 600 && run < 1000;
      if (!hold_done && run >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && run >= 1400) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_frame(make_frame($urandom_range(9) == 0 ? 24'hFFFFFF : 24'($urandom),
                              pick_card(), 8'($urandom),
                              $urandom_range(1) ? 8'h00 : 8'($urandom),
                              8'($urandom), ChkClean, -1));
      end else if (kind < 85) begin
        send_frame(make_frame(24'($urandom), pick_card(), 8'($urandom),
                              $urandom_range(1) ? 8'h00 : 8'($urandom), 8'($urandom),
                              chk_fault_e'($urandom_range(3, 1)), -1));
      end else begin
        // Noise: a random burst, then fill up to the next frame boundary.
        repeat ($urandom_range(40, 1)) send_byte(8'($urandom));
        while (sb.pos != 0) send_byte(8'($urandom));
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && sb.pending() == 0)
      $display("** status_frame_checker_unit: PASSED **");
    else
      $display("** status_frame_checker_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
